// File: src/gieu_pkg.sv
package gieu_pkg;

  localparam int IDX_W    = 6;
  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 64;
  localparam logic [IDX_W-1:0] LINK_REG = 6'd31;

  localparam logic [31:0] LO14   = 32'h0000_3FFF;
  localparam logic [31:0] HI18   = 32'hFFFF_C000;
  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  // Operation codes
  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_LDI = 6'd1, OP_LDIHI = 6'd2, OP_ORI = 6'd3, OP_XORI = 6'd4,
    OP_MOD = 6'd5, OP_SHL = 6'd6, OP_SHLR = 6'd7, OP_SHR = 6'd8, OP_ASR = 6'd9,
    OP_DIV = 6'd10, OP_MUL = 6'd11, OP_MULU = 6'd12, OP_XOR = 6'd13, OP_OR = 6'd14,
    OP_NOR = 6'd15, OP_AND = 6'd16, OP_ANDI = 6'd17, OP_SUB = 6'd18, OP_ADD = 6'd19,
    OP_ADDI = 6'd20, OP_SEB = 6'd21, OP_SLTI = 6'd22, OP_SLT = 6'd23,
    OP_SLTIU = 6'd24, OP_SLTU = 6'd25, OP_MOVZ = 6'd26, OP_MOVN = 6'd27,
    OP_JEQZ = 6'd28, OP_JNEZ = 6'd29, OP_JEQ = 6'd30, OP_JLEZ = 6'd31,
    OP_JLTZ = 6'd32, OP_JGTZ = 6'd33, OP_JNE = 6'd34, OP_JUMP = 6'd35,
    OP_JUMPR = 6'd36, OP_CALL = 6'd37
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_UNSUP = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_RDT, S_EXEC, S_ITER, S_FIX, S_WR1, S_WR2, S_OUT
  } state_t;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] opa;
    logic [31:0] opb;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } iter_rsp_t;

  // Register file write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      data;
  } rf_wr_t;

endpackage

// File: src/gieu_regfile.sv
module gieu_regfile
  import gieu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [31:0]      rd_data,
  input  rf_wr_t           wr
);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [31:0]         data_r;
  logic                hit_r;

  // storage, written and read in the clock
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    data_r <= mem[rd_idx];
  end

  // per-entry valid bits give the all-zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.idx] <= 1'b1;
      end
      hit_r <= vld_r[rd_idx] && ({1'b0, rd_idx} < 7'(NUM_REGS));
    end
  end

  assign rd_data = hit_r ? data_r : 32'd0;

endmodule

// File: src/gieu_iter.sv
module gieu_iter
  import gieu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic [31:0] hi_r, lo_r, dv_r;
  logic [4:0]  cnt_r;
  logic        busy_r, div_r;
  logic [32:0] msum, shifted;
  logic [33:0] diff;
  logic        ge;

  // an adder for multiply and a trial subtractor for divide
  always_comb begin
    msum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, dv_r} : 33'd0);
    shifted = {hi_r, lo_r[31]};
    diff    = {1'b0, shifted} - {2'b0, dv_r};
    ge      = !diff[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: {hi,lo} shifts one bit a step
  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r  <= 32'd0;
      lo_r  <= req.opa;
      dv_r  <= req.opb;
      div_r <= req.is_div;
    end else if (busy_r) begin
      if (div_r) begin
        hi_r <= ge ? diff[31:0] : shifted[31:0];
        lo_r <= {lo_r[30:0], ge};
      end else begin
        hi_r <= msum[32:1];
        lo_r <= {msum[0], lo_r[31:1]};
      end
    end
  end

  assign rsp.done = busy_r && (cnt_r == 5'd31);
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

// File: src/guest_integer_execute_unit.sv
// Guest integer execute unit.
// Input channel in_*: one decoded instruction per transfer; in_tdata holds
// mode, src_a, src_b, dest_low, dest_high, immediate, upper_part and
// guest_address from the lowest bit up. Result channel out_*: exactly one
// result per instruction, in order.
// The unit takes one instruction at a time; in_tready is high only when idle.
// An instruction reads its operands from a 64 x 32 register file with one
// read port, one register a cycle, then executes. Simple operations pass
// through RDA, RDB, RDT, EXEC, WR1, WR2 and OUT; multiply, divide and
// remainder also pass ITER and FIX after EXEC (not on a zero divisor);
// in ITER the shared shift/add unit takes one cycle per bit over 32 bits,
// and FIX fixes the sign. Register writes go through the single write port
// in WR1 then WR2. Reset clears the register file (per-entry valid bits)
// and the split-load latch. A stalled result is held stable on out_tdata
// until taken; no new instruction is accepted meanwhile.
module guest_integer_execute_unit
  import gieu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[5:0] src_a[11:6] src_b[17:12] dest_low[23:18] dest_high[29:24]
  // immediate[61:30] upper_part[79:62] guest_address[111:80]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // write_valid[0] write_index[6:1] write_value[38:7] second_valid[39]
  // second_value[71:40] branch_taken[72] indirect_exit[73] exit_target[105:74]
  // status[107:106], zero above
  output logic [111:0] out_tdata
);

  state_t state_r, state_nxt;

  // latched instruction
  logic [5:0]  mode_r, ia_r, ib_r, id_r, ih_r;
  logic [31:0] imm_r, addr_r;
  logic [17:0] up_r;
  logic [5:0]  latch_r;
  logic [31:0] a_r, b_r;

  // results
  logic        wv_r, sv_r, tk_r, ind_r, neg_r;
  logic [5:0]  widx_r;
  logic [31:0] wval_r, sval_r, tgt_r;
  status_t     st_r;

  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_data;
  rf_wr_t           wr;
  iter_req_t        req;
  iter_rsp_t        rsp;

  gieu_regfile u_rf (.clk(clk), .rst_n(rst_n), .rd_idx(rd_idx), .rd_data(rd_data), .wr(wr));
  gieu_iter    u_it (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  function automatic logic idx_ok(input logic [5:0] i);
    return {1'b0, i} < 7'(NUM_REGS);
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  logic is_mul, is_div, is_signed_mul;
  assign is_mul        = (mode_r == OP_MUL) || (mode_r == OP_MULU);
  assign is_div        = (mode_r == OP_DIV) || (mode_r == OP_MOD);
  assign is_signed_mul = (mode_r == OP_MUL);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_RDT;
      S_RDT:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = (is_mul || (is_div && b_r != 32'd0)) ? S_ITER : S_WR1;
      S_ITER: if (rsp.done) state_nxt = S_FIX;
      S_FIX:  state_nxt = S_WR1;
      S_WR1:  state_nxt = S_WR2;
      S_WR2:  state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      latch_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC && mode_r == OP_LDI) begin
        latch_r <= ib_r;
      end
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    rd_idx     = ia_r;
    unique case (state_r)
      S_RDB:   rd_idx = ib_r;
      S_RDT:   rd_idx = latch_r;
      default: rd_idx = ia_r;
    endcase
    wr.en   = 1'b0;
    wr.idx  = widx_r;
    wr.data = wval_r;
    if (state_r == S_WR1) begin
      wr.en = wv_r;
    end else if (state_r == S_WR2) begin
      wr.en   = sv_r;
      wr.idx  = ih_r;
      wr.data = sval_r;
    end
    req.start  = (state_r == S_EXEC) && (is_mul || (is_div && b_r != 32'd0));
    req.is_div = is_div;
    req.opa    = (is_div || is_signed_mul) ? mag(a_r) : a_r;
    req.opb    = (is_div || is_signed_mul) ? mag(b_r) : b_r;
  end

  // capture instruction and operands
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      mode_r <= in_tdata[5:0];
      ia_r   <= in_tdata[11:6];
      ib_r   <= in_tdata[17:12];
      id_r   <= in_tdata[23:18];
      ih_r   <= in_tdata[29:24];
      imm_r  <= in_tdata[61:30];
      up_r   <= in_tdata[79:62];
      addr_r <= in_tdata[111:80];
    end
    if (state_r == S_RDB) a_r <= rd_data;
    if (state_r == S_RDT) b_r <= rd_data;
  end

  // operations computed combinationally in EXEC
  logic        e_do, e_tk, e_ind;
  logic [5:0]  e_idx;
  logic [31:0] e_val, e_tgt, t_val;
  logic [4:0]  sh;
  status_t     e_st;

  assign sh    = ia_r[4:0];
  assign t_val = rd_data;

  always_comb begin
    e_do  = 1'b0;
    e_tk  = 1'b0;
    e_ind = 1'b0;
    e_idx = id_r;
    e_val = 32'd0;
    e_tgt = 32'd0;
    e_st  = ST_OK;
    unique case (mode_r)
      OP_NOP:   ;
      OP_LDI:   begin e_do = 1'b1; e_idx = ib_r; e_val = (b_r & HI18) | (imm_r & LO14); end
      OP_LDIHI: begin
        e_do = 1'b1; e_idx = latch_r; e_val = (t_val & LO14) | {up_r[17:0], 14'd0};
      end
      OP_ORI:   begin e_do = 1'b1; e_idx = ib_r; e_val = a_r | (imm_r & LO14); end
      OP_XORI:  begin e_do = 1'b1; e_idx = ib_r; e_val = a_r ^ (imm_r & LO14); end
      OP_MOD:   begin e_do = 1'b1; e_idx = ih_r; e_st = ST_DIVZ; end
      OP_DIV:   begin e_do = 1'b1; e_st = ST_DIVZ; end
      OP_SHL:   begin e_do = 1'b1; e_val = b_r << sh; end
      OP_SHLR:  begin e_do = 1'b1; e_val = b_r << a_r[4:0]; end
      OP_SHR:   begin e_do = 1'b1; e_val = b_r >> sh; end
      OP_ASR:   begin e_do = 1'b1; e_val = 32'($signed(b_r) >>> sh); end
      OP_MUL, OP_MULU: ;
      OP_XOR:   begin e_do = 1'b1; e_val = a_r ^ b_r; end
      OP_OR:    begin e_do = 1'b1; e_val = a_r | b_r; end
      OP_NOR:   begin e_do = 1'b1; e_val = ~(a_r | b_r); end
      OP_AND:   begin e_do = 1'b1; e_val = a_r & b_r; end
      OP_ANDI:  begin e_do = 1'b1; e_idx = ib_r; e_val = a_r & (imm_r & LO14); end
      OP_SUB:   begin e_do = 1'b1; e_val = a_r - b_r; end
      OP_ADD:   begin e_do = 1'b1; e_val = a_r + b_r; end
      OP_ADDI:  begin e_do = 1'b1; e_idx = ib_r; e_val = a_r + imm_r; end
      OP_SEB:   begin e_do = 1'b1; e_idx = ia_r; e_val = {{24{b_r[7]}}, b_r[7:0]}; end
      OP_SLTI:  begin
        e_do = 1'b1; e_idx = ib_r; e_val = {31'd0, $signed(a_r) < $signed(imm_r)};
      end
      OP_SLT:   begin e_do = 1'b1; e_val = {31'd0, $signed(a_r) < $signed(b_r)}; end
      OP_SLTIU: begin e_do = 1'b1; e_idx = ib_r; e_val = {31'd0, a_r < (imm_r & LO14)}; end
      OP_SLTU:  begin e_do = 1'b1; e_val = {31'd0, a_r < b_r}; end
      OP_MOVZ:  begin e_do = (b_r == 32'd0); e_val = a_r; end
      OP_MOVN:  begin e_do = (b_r != 32'd0); e_val = a_r; end
      OP_JEQZ:  e_tk = (a_r == 32'd0);
      OP_JNEZ:  e_tk = (a_r != 32'd0);
      OP_JEQ:   e_tk = (a_r == b_r);
      OP_JLEZ:  e_tk = (b_r == 32'd0) || b_r[31];
      OP_JLTZ:  e_tk = b_r[31];
      OP_JGTZ:  e_tk = (b_r != 32'd0) && !b_r[31];
      OP_JNE:   e_tk = (a_r != b_r);
      OP_JUMP:  e_tk = 1'b1;
      OP_JUMPR: begin e_tk = 1'b1; e_ind = 1'b1; e_tgt = b_r; end
      OP_CALL:  begin e_tk = 1'b1; e_do = 1'b1; e_idx = LINK_REG; e_val = addr_r + 32'd4; end
      default:  e_st = ST_UNSUP;
    endcase
    if (!e_do || !idx_ok(e_idx)) begin
      e_do  = 1'b0;
      e_idx = '0;
      e_val = 32'd0;
    end
  end

  // multiply/divide sign fix
  logic [63:0] prod;
  logic [31:0] quo, rem;
  assign prod = neg_r ? (64'd0 - {rsp.hi, rsp.lo}) : {rsp.hi, rsp.lo};
  assign quo  = neg_r ? (32'd0 - rsp.lo) : rsp.lo;
  assign rem  = a_r[31] ? (32'd0 - rsp.hi) : rsp.hi;

  // result registers
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      wv_r   <= e_do;
      widx_r <= e_idx;
      wval_r <= e_val;
      sv_r   <= 1'b0;
      sval_r <= 32'd0;
      tk_r   <= e_tk;
      ind_r  <= e_ind;
      tgt_r  <= e_tgt;
      st_r   <= (is_div && b_r != 32'd0) ? ST_OK : e_st;
      neg_r  <= is_div ? (a_r[31] ^ b_r[31]) : (is_signed_mul && (a_r[31] ^ b_r[31]));
    end else if (state_r == S_FIX) begin
      if (is_div) begin
        wval_r <= (mode_r == OP_MOD) ? rem : quo;
      end else begin
        wv_r   <= (id_r != 6'd0) && idx_ok(id_r);
        widx_r <= ((id_r != 6'd0) && idx_ok(id_r)) ? id_r : 6'd0;
        wval_r <= ((id_r != 6'd0) && idx_ok(id_r)) ? prod[31:0] : 32'd0;
        sv_r   <= (ih_r != 6'd0) && idx_ok(ih_r);
        sval_r <= ((ih_r != 6'd0) && idx_ok(ih_r)) ? prod[63:32] : 32'd0;
      end
    end
  end

  assign out_tdata = {4'd0, st_r, tgt_r, ind_r, tk_r, sval_r, sv_r, wval_r, widx_r, wv_r};

endmodule
